// ----- hdl/tcpu_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpu_pkg : shared constants and types for the two-register CPU execute block
// Instruction field masks, mode and jump codes, memory map and write request.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpu_pkg;

    // Memory map: data RAM and screen RAM are contiguous from address 0,
    // the keyboard word sits directly above them.
    localparam int          MEM_WORDS = 24576;
    localparam int          MEM_AW    = $clog2(MEM_WORDS);
    localparam logic [15:0] KBD_ADDR  = 16'(MEM_WORDS);
    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_WORDS - 1);

    // Modes
    localparam logic [1:0] MODE_EXEC = 2'd0;
    localparam logic [1:0] MODE_KEY  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Instruction fields
    localparam logic [15:0] C_PREFIX  = 16'hE000;
    localparam logic [15:0] BIT_USE_M = 16'h1000;
    localparam logic [15:0] BIT_ZX    = 16'h0800;
    localparam logic [15:0] BIT_NX    = 16'h0400;
    localparam logic [15:0] BIT_ZY    = 16'h0200;
    localparam logic [15:0] BIT_NY    = 16'h0100;
    localparam logic [15:0] BIT_ADD   = 16'h0080;
    localparam logic [15:0] BIT_NO    = 16'h0040;
    localparam logic [15:0] BIT_DST_A = 16'h0020;
    localparam logic [15:0] BIT_DST_D = 16'h0010;
    localparam logic [15:0] BIT_DST_M = 16'h0008;
    localparam logic [15:0] JUMP_MASK = 16'h0007;

    // Jump conditions
    localparam logic [2:0] JMP_NONE = 3'd0;
    localparam logic [2:0] JMP_GT   = 3'd1;
    localparam logic [2:0] JMP_EQ   = 3'd2;
    localparam logic [2:0] JMP_GE   = 3'd3;
    localparam logic [2:0] JMP_LT   = 3'd4;
    localparam logic [2:0] JMP_NE   = 3'd5;
    localparam logic [2:0] JMP_LE   = 3'd6;
    localparam logic [2:0] JMP_ALL  = 3'd7;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] idx;
        logic [15:0]       data;
    } mem_wr_t;

endpackage

`default_nettype wire

// ----- hdl/tcpu_alu.sv -----
// ----------------------------------------------------------------------------
// tcpu_alu : zero/negate/and/add ALU with jump condition decode
// Combinational; operands are D (x) and A or M (y).
// ----------------------------------------------------------------------------
`default_nettype none

module tcpu_alu (
    input  wire logic [15:0] instruction,
    input  wire logic [15:0] x_in,
    input  wire logic [15:0] y_in,
    output logic      [15:0] result,
    output logic             jump
);

    logic [15:0] x_z, x_n, y_z, y_n, r_raw;
    logic        neg, zero;
    logic [2:0]  cond;

    always_comb begin
        x_z   = ((instruction & tcpu_pkg::BIT_ZX) != 16'd0) ? 16'd0 : x_in;
        x_n   = ((instruction & tcpu_pkg::BIT_NX) != 16'd0) ? ~x_z : x_z;
        y_z   = ((instruction & tcpu_pkg::BIT_ZY) != 16'd0) ? 16'd0 : y_in;
        y_n   = ((instruction & tcpu_pkg::BIT_NY) != 16'd0) ? ~y_z : y_z;
        r_raw = ((instruction & tcpu_pkg::BIT_ADD) != 16'd0) ? 16'(x_n + y_n) : (x_n & y_n);
        result = ((instruction & tcpu_pkg::BIT_NO) != 16'd0) ? ~r_raw : r_raw;
    end

    assign neg  = result[15];
    assign zero = (result == 16'd0);
    assign cond = 3'(instruction & tcpu_pkg::JUMP_MASK);

    always_comb begin
        case (cond)
            tcpu_pkg::JMP_NONE: jump = 1'b0;
            tcpu_pkg::JMP_GT:   jump = !neg && !zero;
            tcpu_pkg::JMP_EQ:   jump = zero;
            tcpu_pkg::JMP_GE:   jump = !neg;
            tcpu_pkg::JMP_LT:   jump = neg;
            tcpu_pkg::JMP_NE:   jump = !zero;
            tcpu_pkg::JMP_LE:   jump = neg || zero;
            tcpu_pkg::JMP_ALL:  jump = 1'b1;
            default:            jump = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/tcpu_mem.sv -----
// ----------------------------------------------------------------------------
// tcpu_mem : data and screen RAM with registered read and clearing sweep
// One write and one read port; sweeps zeros through every word after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpu_mem (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [tcpu_pkg::MEM_AW-1:0] rd_idx,
    input  wire tcpu_pkg::mem_wr_t           wr,
    output logic      [15:0]                 rd_data,
    output logic                             busy
);

    logic [15:0] mem [0:tcpu_pkg::MEM_WORDS-1];

    logic                        clr_reg, clr_next;
    logic [tcpu_pkg::MEM_AW-1:0] clr_idx_reg, clr_idx_next;
    logic [15:0]                 rd_data_reg;
    logic                        we;
    logic [tcpu_pkg::MEM_AW-1:0] w_idx;
    logic [15:0]                 w_data;

    function automatic logic [tcpu_pkg::MEM_AW-1:0] MEM_AW_INC(
        input logic [tcpu_pkg::MEM_AW-1:0] v
    );
        return tcpu_pkg::MEM_AW'(v + 1'b1);
    endfunction

    always_comb begin
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        if (clr_reg) begin
            clr_idx_next = MEM_AW_INC(clr_idx_reg);
            if (clr_idx_reg == tcpu_pkg::CLR_LAST) begin
                clr_next = 1'b0;
            end
        end
    end

    assign we     = clr_reg | wr.en;
    assign w_idx  = clr_reg ? clr_idx_reg : wr.idx;
    assign w_data = clr_reg ? 16'd0 : wr.data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end else begin
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[w_idx] <= w_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_reg;

endmodule

`default_nettype wire

// ----- hdl/two_register_cpu_execute.sv -----
// ----------------------------------------------------------------------------
// two_register_cpu_execute : A/D register CPU, one instruction per request
// Pipeline: request and memory read registered into execute, result into output.
// Throughput: 1 request per cycle unless m_ready holds the output; a C-instruction
// reading M right behind one whose ALU writes A waits for it to leave execute.
// Reset: A, D, PC and keyboard word clear at once; RAM and screen are swept
// to zero word by word, with s_ready low until the sweep ends.
// ----------------------------------------------------------------------------
`default_nettype none

module two_register_cpu_execute (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [15:0] s_instruction,
    input  wire logic [7:0]  s_key_code,
    input  wire logic [15:0] s_peek_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [15:0] m_next_pc,
    output logic      [15:0] m_a_value,
    output logic      [15:0] m_d_value,
    output logic             m_mem_write,
    output logic      [15:0] m_mem_address,
    output logic      [15:0] m_mem_data,
    output logic      [15:0] m_read_data,
    output logic             m_bad_access
);

    // architectural state
    logic [15:0] a_reg, a_next, d_reg, d_next, pc_reg, pc_next, kbd_reg, kbd_next;

    // execute stage
    logic        s2_valid_reg, s2_valid_next;
    logic [1:0]  s2_mode_reg;
    logic [15:0] s2_ins_reg;
    logic [7:0]  s2_key_reg;
    logic [15:0] s2_raddr_reg;
    logic        fwd_hit_reg;
    logic [15:0] fwd_data_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] o_pc_reg, o_a_reg, o_d_reg, o_maddr_reg, o_mdata_reg, o_rdata_reg;
    logic        o_mwr_reg, o_bad_reg;

    logic        accept, s2_adv, hazard, in_is_c, in_needs_a;
    logic        s2_is_c, s2_exec_c, s2_use_m, s2_dst_m;
    logic [15:0] a_fwd, rd_addr;
    logic [15:0] mem_rd_data, mem_word, rd_word, alu_y, alu_r;
    logic        mem_busy, rd_bad, st_bad, alu_jump, bad, st_kbd;
    logic [15:0] pc_inc;
    tcpu_pkg::mem_wr_t mem_wr;

    // ---------------- request side ----------------
    assign in_is_c    = (s_instruction & tcpu_pkg::C_PREFIX) == tcpu_pkg::C_PREFIX;
    assign in_needs_a = (s_mode == tcpu_pkg::MODE_EXEC) && in_is_c
                        && ((s_instruction & tcpu_pkg::BIT_USE_M) != 16'd0);

    assign s2_is_c   = (s2_ins_reg & tcpu_pkg::C_PREFIX) == tcpu_pkg::C_PREFIX;
    assign s2_exec_c = (s2_mode_reg == tcpu_pkg::MODE_EXEC) && s2_is_c;
    assign s2_use_m  = (s2_ins_reg & tcpu_pkg::BIT_USE_M) != 16'd0;
    assign s2_dst_m  = (s2_ins_reg & tcpu_pkg::BIT_DST_M) != 16'd0;

    // A-instruction in execute is forwarded; an ALU write to A interlocks
    assign a_fwd = (s2_valid_reg && (s2_mode_reg == tcpu_pkg::MODE_EXEC) && !s2_is_c)
                   ? s2_ins_reg : a_reg;
    assign hazard = in_needs_a && s2_valid_reg && s2_exec_c
                    && ((s2_ins_reg & tcpu_pkg::BIT_DST_A) != 16'd0);

    assign s2_adv  = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !mem_busy && (!s2_valid_reg || s2_adv) && !hazard;
    assign accept  = s_valid && s_ready;
    assign rd_addr = (s_mode == tcpu_pkg::MODE_PEEK) ? s_peek_address : a_fwd;

    tcpu_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_idx  (rd_addr[tcpu_pkg::MEM_AW-1:0]),
        .wr      (mem_wr),
        .rd_data (mem_rd_data),
        .busy    (mem_busy)
    );

    // ---------------- execute ----------------
    assign mem_word = fwd_hit_reg ? fwd_data_reg : mem_rd_data;

    always_comb begin
        rd_bad = 1'b0;
        if (s2_raddr_reg < tcpu_pkg::KBD_ADDR) begin
            rd_word = mem_word;
        end else if (s2_raddr_reg == tcpu_pkg::KBD_ADDR) begin
            rd_word = kbd_reg;
        end else begin
            rd_word = 16'd0;
            rd_bad  = 1'b1;
        end
    end

    assign alu_y = s2_use_m ? rd_word : a_reg;

    tcpu_alu u_alu (
        .instruction (s2_ins_reg),
        .x_in        (d_reg),
        .y_in        (alu_y),
        .result      (alu_r),
        .jump        (alu_jump)
    );

    assign st_bad = a_reg > tcpu_pkg::KBD_ADDR;
    assign st_kbd = a_reg == tcpu_pkg::KBD_ADDR;
    assign pc_inc = 16'(pc_reg + 16'd1);

    assign mem_wr.en   = s2_adv && s2_exec_c && s2_dst_m && (a_reg < tcpu_pkg::KBD_ADDR);
    assign mem_wr.idx  = a_reg[tcpu_pkg::MEM_AW-1:0];
    assign mem_wr.data = alu_r;

    always_comb begin
        a_next   = a_reg;
        d_next   = d_reg;
        pc_next  = pc_reg;
        kbd_next = kbd_reg;
        bad      = 1'b0;
        case (s2_mode_reg)
            tcpu_pkg::MODE_EXEC: begin
                if (!s2_is_c) begin
                    a_next  = s2_ins_reg;
                    pc_next = pc_inc;
                end else begin
                    pc_next = alu_jump ? a_reg : pc_inc;
                    if ((s2_ins_reg & tcpu_pkg::BIT_DST_A) != 16'd0) begin
                        a_next = alu_r;
                    end
                    if ((s2_ins_reg & tcpu_pkg::BIT_DST_D) != 16'd0) begin
                        d_next = alu_r;
                    end
                    if (s2_dst_m && st_kbd) begin
                        kbd_next = alu_r;
                    end
                    bad = (s2_use_m && rd_bad) || (s2_dst_m && st_bad);
                end
            end
            tcpu_pkg::MODE_KEY: begin
                kbd_next = {8'd0, s2_key_reg};
            end
            tcpu_pkg::MODE_PEEK: begin
                bad = rd_bad;
            end
            default: begin
            end
        endcase
    end

    assign s2_valid_next = accept ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
    assign m_valid_next  = s2_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg        <= 16'd0;
            d_reg        <= 16'd0;
            pc_reg       <= 16'd0;
            kbd_reg      <= 16'd0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s2_adv) begin
                a_reg   <= a_next;
                d_reg   <= d_next;
                pc_reg  <= pc_next;
                kbd_reg <= kbd_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_mode_reg  <= s_mode;
            s2_ins_reg   <= s_instruction;
            s2_key_reg   <= s_key_code;
            s2_raddr_reg <= rd_addr;
            // word being stored this edge is missed by the read: forward it
            fwd_hit_reg  <= mem_wr.en && (mem_wr.idx == rd_addr[tcpu_pkg::MEM_AW-1:0]);
            fwd_data_reg <= mem_wr.data;
        end
        if (s2_adv) begin
            o_pc_reg    <= pc_next;
            o_a_reg     <= a_next;
            o_d_reg     <= d_next;
            o_mwr_reg   <= s2_exec_c && s2_dst_m;
            o_maddr_reg <= (s2_exec_c && s2_dst_m) ? a_reg : 16'd0;
            o_mdata_reg <= (s2_exec_c && s2_dst_m) ? alu_r : 16'd0;
            o_rdata_reg <= (s2_mode_reg == tcpu_pkg::MODE_PEEK) ? rd_word : 16'd0;
            o_bad_reg   <= bad;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_next_pc     = o_pc_reg;
    assign m_a_value     = o_a_reg;
    assign m_d_value     = o_d_reg;
    assign m_mem_write   = o_mwr_reg;
    assign m_mem_address = o_maddr_reg;
    assign m_mem_data    = o_mdata_reg;
    assign m_read_data   = o_rdata_reg;
    assign m_bad_access  = o_bad_reg;

    // ---------------- assertions ----------------
    a_no_req_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mem_busy)
        else $error("request accepted during memory clear");

    a_read_addr_matches_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_exec_c && s2_use_m) |-> (s2_raddr_reg == a_reg))
        else $error("M operand read at stale A");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s2_valid_reg)
        else $error("accepted request lost before execute");

    a_store_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr.en |-> (s2_adv && !mem_busy))
        else $error("memory store outside execute advance");

endmodule

`default_nettype wire
